FILE: sv/rgb_median_filter_3x3_core_defines.svh
// Assertion macros shared by the median filter modules
`ifndef RGB_MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`define RGB_MEDIAN_FILTER_3X3_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define RMF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmf: check failed");

// next-cycle implication
`define RMF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmf: check failed");

`endif

FILE: sv/rmf_pkg.sv
// Types, constants and compare helpers for the 3x3 RGB median filter
package rmf_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int CFG_W         = 12;
	localparam int MASK          = 3;
	localparam int WIN_N         = MASK * MASK;

	localparam logic [CFG_W-1:0] IMG_W_RST = 12'd640;
	localparam logic [CFG_W-1:0] IMG_H_RST = 12'd480;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_t;

	// index = row*3 + column, row 0 is the oldest line
	typedef pix_t [WIN_N-1:0] win_t;

	typedef struct packed {
		win_t win;
		logic border;
		logic last;
	} job_t;

	function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic pix_t px_min3(input pix_t a, input pix_t b, input pix_t c);
		pix_t o;
		o.r = min2(min2(a.r, b.r), c.r);
		o.g = min2(min2(a.g, b.g), c.g);
		o.b = min2(min2(a.b, b.b), c.b);
		return o;
	endfunction

	function automatic pix_t px_max3(input pix_t a, input pix_t b, input pix_t c);
		pix_t o;
		o.r = max2(max2(a.r, b.r), c.r);
		o.g = max2(max2(a.g, b.g), c.g);
		o.b = max2(max2(a.b, b.b), c.b);
		return o;
	endfunction

	function automatic pix_t px_med3(input pix_t a, input pix_t b, input pix_t c);
		pix_t o;
		o.r = med3(a.r, b.r, c.r);
		o.g = med3(a.g, b.g, c.g);
		o.b = med3(a.b, b.b, c.b);
		return o;
	endfunction

endpackage

FILE: sv/rmf_stream_if.sv
// Pixel stream interfaces for the median filter input and output
interface rmf_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic       flush;

	modport source (output valid, in_red, in_green, in_blue, flush, input ready);
	modport sink   (input valid, in_red, in_green, in_blue, flush, output ready);
endinterface

interface rmf_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       out_last;

	modport source (output valid, out_red, out_green, out_blue, out_last, input ready);
	modport sink   (input valid, out_red, out_green, out_blue, out_last, output ready);
endinterface

FILE: sv/rgb_median_filter_3x3_core.sv
// Top level of the streaming 3x3 RGB median filter
//
//   port     role     handshake          carries
//   pix_in   sink     valid/ready        in_red, in_green, in_blue, flush
//   pix_out  source   valid/ready        out_red, out_green, out_blue, out_last
//   apb      slave    psel/penable       image_width @0x0, image_height @0x4
//
// One pixel per clock sustained while pix_out is ready; a result passes the
// line store read, window update, queue and three median stages.
// Line stores are single-write memories; the window is updated as an item leaves
// the front stage, so a stalled output backs up through the two-entry queue to pix_in.ready.
// Reset clears counters, window and queue; line store contents are not cleared.
// A register write restarts the image.

module rgb_median_filter_3x3_core #(
	parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rmf_pix_in_if.sink  pix_in,
	rmf_pix_out_if.source pix_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rmf_pkg::*;

	logic [CFG_W-1:0] width_q, height_q;
	logic             wr;
	reg_idx_t         idx;
	pix_t             in_pix, out_pix;
	logic             job_valid, job_ready, q_valid, q_ready;
	job_t             job, q_job;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMG_W_RST;
			height_q <= IMG_H_RST;
		end else if (wr) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	assign in_pix.r = pix_in.in_red;
	assign in_pix.g = pix_in.in_green;
	assign in_pix.b = pix_in.in_blue;

	rmf_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (wr),
		.img_width  (width_q),
		.img_height (height_q),
		.in_valid   (pix_in.valid),
		.in_ready   (pix_in.ready),
		.in_pix     (in_pix),
		.in_flush   (pix_in.flush),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	rmf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_data  (job),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_job)
	);

	rmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.out_pix   (out_pix),
		.out_last  (pix_out.out_last)
	);

	assign pix_out.out_red   = out_pix.r;
	assign pix_out.out_green = out_pix.g;
	assign pix_out.out_blue  = out_pix.b;

endmodule

FILE: sv/rmf_front.sv
// Front end: raster counters, line stores and the 3x3 window
`include "rgb_median_filter_3x3_core_defines.svh"

module rmf_front #(
	parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic [rmf_pkg::CFG_W-1:0]   img_width,
	input  logic [rmf_pkg::CFG_W-1:0]   img_height,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rmf_pkg::pix_t               in_pix,
	input  logic                        in_flush,
	output logic                        job_valid,
	input  logic                        job_ready,
	output rmf_pkg::job_t               job
);
	import rmf_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WB  = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (WB > CFG_W) ? WB : CFG_W;
	localparam int RW  = CFG_W + 1;

	logic [EW-1:0]    eff_w;
	logic [CFG_W-1:0] eff_h;

	logic [CW-1:0]    in_col_q;
	logic [RW-1:0]    in_row_q;
	logic [CW-1:0]    out_col_q;
	logic [CFG_W-1:0] out_row_q;

	logic             drain, acc, take, emit, border, last, wrap, owrap;
	logic [EW:0]      ci, oc1;
	logic [RW-1:0]    or1;

	logic             v_s1, emit_s1, border_s1, last_s1, leave;
	pix_t             pix_s1;
	logic [CW-1:0]    col_s1;

	logic [23:0]      up_mem [MAX_WIDTH];
	logic [23:0]      lo_mem [MAX_WIDTH];
	logic [23:0]      up_rd_q, lo_rd_q;
	logic             fwd_q;
	pix_t             fwd_top_q, fwd_mid_q;
	pix_t             top_eff, mid_eff;

	win_t             win_q, win_nx;

	always_comb begin
		if (img_width == '0) begin
			eff_w = EW'(1);
		end else if (EW'(img_width) > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(img_width);
		end
		eff_h = (img_height == '0) ? CFG_W'(1) : img_height;
	end

	assign drain  = in_row_q >= RW'(eff_h);
	assign acc    = in_valid && in_ready;
	// a flush item inside the image is swallowed
	assign take   = acc && (drain || !in_flush);
	assign emit   = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
	assign ci     = (EW + 1)'(in_col_q) + (EW + 1)'(1);
	assign wrap   = ci >= (EW + 1)'(eff_w);
	assign oc1    = (EW + 1)'(out_col_q) + (EW + 1)'(1);
	assign owrap  = oc1 >= (EW + 1)'(eff_w);
	assign or1    = RW'(out_row_q) + RW'(1);
	assign border = out_row_q == '0 || or1 >= RW'(eff_h) || out_col_q == '0 || owrap;
	assign last   = or1 >= RW'(eff_h) && owrap;

	assign leave    = v_s1 && (!emit_s1 || job_ready);
	assign in_ready = !v_s1 || leave;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= wrap ? '0 : ci[CW-1:0];
				in_row_q <= wrap ? in_row_q + RW'(1) : in_row_q;
				if (emit) begin
					out_col_q <= owrap ? '0 : oc1[CW-1:0];
					out_row_q <= owrap ? out_row_q + CFG_W'(1) : out_row_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (leave) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1    <= drain ? '0 : in_pix;
			col_s1    <= in_col_q;
			emit_s1   <= emit;
			border_s1 <= border;
			last_s1   <= last;
		end
	end

	// line store read, registered
	always_ff @(posedge clk) begin
		if (take) begin
			up_rd_q <= up_mem[in_col_q];
			lo_rd_q <= lo_mem[in_col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (leave) begin
			up_mem[col_s1] <= mid_eff;
			lo_mem[col_s1] <= pix_s1;
		end
	end

	// same column written on the edge the read was taken (width of one)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (take) begin
			fwd_q <= leave && col_s1 == in_col_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fwd_top_q <= mid_eff;
			fwd_mid_q <= pix_s1;
		end
	end

	assign top_eff = fwd_q ? fwd_top_q : pix_t'(up_rd_q);
	assign mid_eff = fwd_q ? fwd_mid_q : pix_t'(lo_rd_q);

	always_comb begin
		for (int r = 0; r < MASK; r++) begin
			win_nx[r*MASK]     = win_q[r*MASK + 1];
			win_nx[r*MASK + 1] = win_q[r*MASK + 2];
		end
		win_nx[2] = top_eff;
		win_nx[5] = mid_eff;
		win_nx[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (restart) begin
			win_q <= '0;
		end else if (leave) begin
			win_q <= win_nx;
		end
	end

	assign job_valid  = v_s1 && emit_s1;
	assign job.win    = win_nx;
	assign job.border = border_s1;
	assign job.last   = last_s1;

	`RMF_ASSERT_NEXT(a_last_wrap, take && emit && last && !restart, in_col_q == '0 && in_row_q == '0)
	`RMF_ASSERT_IMPL(a_last_on_edge, take && emit && last, border)

endmodule

FILE: sv/rmf_queue.sv
// Two-entry queue of window requests between front and back
`include "rgb_median_filter_3x3_core_defines.svh"

module rmf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rmf_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output rmf_pkg::job_t pop_data
);
	import rmf_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`RMF_ASSERT_NEXT(a_cnt_pop, pop && !push, cnt_q == $past(cnt_q) - 2'd1)

endmodule

FILE: sv/rmf_back.sv
// Back end: three-stage median network whose last stage is the output register
`include "rgb_median_filter_3x3_core_defines.svh"

module rmf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  rmf_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output rmf_pkg::pix_t out_pix,
	output logic          out_last
);
	import rmf_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;
	pix_t lo_s1 [MASK];
	pix_t md_s1 [MASK];
	pix_t hi_s1 [MASK];
	pix_t ctr_s1, ctr_s2;
	logic border_s1, border_s2, border_s3;
	logic last_s1, last_s2, last_s3;
	pix_t a_s2, b_s2, c_s2;
	pix_t res_s3;

	assign en        = !v_s3 || out_ready;
	assign job_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// sort each column
			for (int c = 0; c < MASK; c++) begin
				lo_s1[c] <= px_min3(job.win[c], job.win[MASK + c], job.win[2*MASK + c]);
				md_s1[c] <= px_med3(job.win[c], job.win[MASK + c], job.win[2*MASK + c]);
				hi_s1[c] <= px_max3(job.win[c], job.win[MASK + c], job.win[2*MASK + c]);
			end
			ctr_s1    <= job.win[WIN_N / 2];
			border_s1 <= job.border;
			last_s1   <= job.last;

			a_s2      <= px_max3(lo_s1[0], lo_s1[1], lo_s1[2]);
			b_s2      <= px_med3(md_s1[0], md_s1[1], md_s1[2]);
			c_s2      <= px_min3(hi_s1[0], hi_s1[1], hi_s1[2]);
			ctr_s2    <= ctr_s1;
			border_s2 <= border_s1;
			last_s2   <= last_s1;

			res_s3    <= border_s2 ? ctr_s2 : px_med3(a_s2, b_s2, c_s2);
			border_s3 <= border_s2;
			last_s3   <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_pix   = res_s3;
	assign out_last  = last_s3;

	`RMF_ASSERT_IMPL(a_last_border, v_s3 && last_s3, border_s3)

endmodule
